// ===== sv/sb64_pkg.sv =====
// Package for the strict base64 decoder.
// Holds the character classes, the result group type and the alphabet decode function.
// No dependencies.
package sb64_pkg;

    // Character codes and sextet offsets of the base64 alphabet.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic [5:0] OFS_LOWER = 6'd26;
    localparam logic [5:0] OFS_DIGIT = 6'd52;
    localparam logic [5:0] VAL_PLUS  = 6'd62;
    localparam logic [5:0] VAL_SLASH = 6'd63;

    // Input item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_PAD,
        CLS_SKIP,
        CLS_BAD
    } sym_class_t;

    typedef struct packed {
        sym_class_t kind;
        logic [5:0] value;
    } cls_t;

    // All results caused by one input transaction: up to three bytes and an
    // optional done result, which always comes last.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            has_done;
        logic            fail;
    } group_t;

    // Map one character to its sextet value or to its class.
    function automatic cls_t classify(logic [7:0] ch);
        cls_t r;
        r.kind  = CLS_BAD;
        r.value = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            r.kind  = CLS_DATA;
            r.value = 6'(ch - CH_UPPER_A);
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            r.kind  = CLS_DATA;
            r.value = 6'(ch - CH_LOWER_A) + OFS_LOWER;
        end
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
        begin
            r.kind  = CLS_DATA;
            r.value = 6'(ch - CH_DIGIT_0) + OFS_DIGIT;
        end
        else if (ch == CH_PLUS)
        begin
            r.kind  = CLS_DATA;
            r.value = VAL_PLUS;
        end
        else if (ch == CH_SLASH)
        begin
            r.kind  = CLS_DATA;
            r.value = VAL_SLASH;
        end
        else if (ch == CH_PAD)
        begin
            r.kind = CLS_PAD;
        end
        else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))
        begin
            r.kind = CLS_SKIP;
        end
        return r;
    endfunction

endpackage

// ===== sv/sb64_char_if.sv =====
// Character input channel of the strict base64 decoder.
// Carries valid, ready and the kind and symbol fields. No dependencies.
interface sb64_char_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

// ===== sv/sb64_res_if.sv =====
// Result output channel of the strict base64 decoder.
// Carries valid, ready and the decoded byte and status fields. No dependencies.
interface sb64_res_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] decoded_byte;
    logic       done_res;
    logic       failed;

    modport source (output valid, output has_byte, output decoded_byte,
                    output done_res, output failed, input ready);
    modport sink   (input valid, input has_byte, input decoded_byte,
                    input done_res, input failed, output ready);
endinterface

// ===== sv/strict_base64_decoder_top.sv =====
// Top level of the strict streaming base64 decoder.
// Depends on sb64_pkg, sb64_char_if and sb64_res_if.
//
//  Channel   Dir  Payload                                    Per transaction
//  chars     in   kind, symbol                               one character or end
//  results   out  has_byte, decoded_byte, done_res, failed   one byte or done result
//
// A character transaction is decoded in the cycle it is accepted; its results
// (up to three) are written as one group into a two-slot group queue.
// The results port drains one result per cycle from the head group while
// results.ready is high, and chars can keep accepting meanwhile.
// chars.ready is low only while the second queue slot is occupied.
// Reset clears the decoder state and empties the queue; no clearing pass.
module strict_base64_decoder_top (
    input logic        clk,
    input logic        rst_n,
    sb64_char_if.sink  chars,
    sb64_res_if.source results
);
    import sb64_pkg::*;

    // Decoder state.
    logic [17:0] sextet_reg, sextet_next;
    logic [1:0]  pos_reg, pos_next;
    logic        twp_reg, twp_next;
    logic        pqs_reg, pqs_next;
    logic        err_reg, err_next;
    logic        anyb_reg, anyb_next;

    // Group queue: head slot being drained and one waiting slot.
    group_t      act_reg, act_next;
    logic        act_valid_reg, act_valid_next;
    group_t      pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [1:0]  idx_reg, idx_next;

    cls_t        cls;
    group_t      grp;
    logic        accept;
    logic        grp_nonempty;
    logic        out_fire;
    logic        out_last;
    logic [1:0]  last_idx;

    assign accept      = chars.valid && chars.ready;
    assign chars.ready = !pend_valid_reg;
    assign cls         = classify(chars.symbol);

    // Decode one transaction: next state and the group of results it causes.
    always_comb
    begin
        sextet_next = sextet_reg;
        pos_next    = pos_reg;
        twp_next    = twp_reg;
        pqs_next    = pqs_reg;
        err_next    = err_reg;
        anyb_next   = anyb_reg;
        grp.bytes   = '0;
        grp.nbytes  = 2'd0;
        grp.has_done = 1'b0;
        grp.fail    = 1'b0;

        if (chars.kind == KIND_END)
        begin
            // Flush a partial quad with implicit padding, then report.
            if (!err_reg)
            begin
                unique case (pos_reg)
                    2'd2:
                    begin
                        grp.bytes[0] = sextet_reg[11:4];
                        grp.nbytes   = 2'd1;
                    end
                    2'd3:
                    begin
                        grp.bytes[0] = sextet_reg[17:10];
                        grp.bytes[1] = sextet_reg[9:2];
                        grp.nbytes   = twp_reg ? 2'd1 : 2'd2;
                    end
                    default:
                    begin
                        grp.nbytes = 2'd0;
                    end
                endcase
            end
            grp.has_done = 1'b1;
            grp.fail     = err_reg || (pos_reg == 2'd1)
                         || !(anyb_reg || (grp.nbytes != 2'd0));
            // Back to the reset state for the next string.
            sextet_next = '0;
            pos_next    = 2'd0;
            twp_next    = 1'b0;
            pqs_next    = 1'b0;
            err_next    = 1'b0;
            anyb_next   = 1'b0;
        end
        else if (!err_reg && cls.kind != CLS_SKIP)
        begin
            if (cls.kind == CLS_BAD || pqs_reg)
            begin
                err_next = 1'b1;
            end
            else if (cls.kind == CLS_PAD)
            begin
                // Padding is legal only in the third and fourth places.
                priority if (pos_reg < 2'd2)
                begin
                    err_next = 1'b1;
                end
                else if (pos_reg == 2'd2)
                begin
                    sextet_next = {sextet_reg[11:0], 6'd0};
                    twp_next    = 1'b1;
                    pos_next    = 2'd3;
                end
                else
                begin
                    grp.bytes[0] = sextet_reg[17:10];
                    grp.bytes[1] = sextet_reg[9:2];
                    grp.nbytes   = twp_reg ? 2'd1 : 2'd2;
                    anyb_next    = 1'b1;
                    pqs_next     = 1'b1;
                    sextet_next  = '0;
                    pos_next     = 2'd0;
                    twp_next     = 1'b0;
                end
            end
            else if (pos_reg != 2'd3)
            begin
                sextet_next = {sextet_reg[11:0], cls.value};
                pos_next    = pos_reg + 2'd1;
            end
            else if (twp_reg)
            begin
                err_next = 1'b1;
            end
            else
            begin
                // Fourth sextet completes a full quad of three bytes.
                grp.bytes[0] = sextet_reg[17:10];
                grp.bytes[1] = sextet_reg[9:2];
                grp.bytes[2] = {sextet_reg[1:0], cls.value};
                grp.nbytes   = 2'd3;
                anyb_next    = 1'b1;
                sextet_next  = '0;
                pos_next     = 2'd0;
            end
        end
    end

    assign grp_nonempty = (grp.nbytes != 2'd0) || grp.has_done;

    // Output selection from the head group.
    assign last_idx = act_reg.has_done ? act_reg.nbytes : act_reg.nbytes - 2'd1;
    assign out_last = (idx_reg == last_idx);
    assign out_fire = results.valid && results.ready;

    assign results.valid        = act_valid_reg;
    assign results.has_byte     = (idx_reg < act_reg.nbytes);
    assign results.decoded_byte = (idx_reg < act_reg.nbytes) ? act_reg.bytes[idx_reg] : 8'd0;
    assign results.done_res     = (idx_reg >= act_reg.nbytes);
    assign results.failed       = (idx_reg >= act_reg.nbytes) && act_reg.fail;

    // Group queue control.
    always_comb
    begin
        act_next        = act_reg;
        act_valid_next  = act_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        idx_next        = idx_reg;

        if (out_fire)
        begin
            if (out_last)
            begin
                idx_next       = 2'd0;
                act_valid_next = pend_valid_reg;
                act_next       = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end

        if (accept && grp_nonempty)
        begin
            if (!act_valid_next)
            begin
                act_next       = grp;
                act_valid_next = 1'b1;
            end
            else
            begin
                pend_next       = grp;
                pend_valid_next = 1'b1;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sextet_reg     <= '0;
            pos_reg        <= 2'd0;
            twp_reg        <= 1'b0;
            pqs_reg        <= 1'b0;
            err_reg        <= 1'b0;
            anyb_reg       <= 1'b0;
            act_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                sextet_reg <= sextet_next;
                pos_reg    <= pos_next;
                twp_reg    <= twp_next;
                pqs_reg    <= pqs_next;
                err_reg    <= err_next;
                anyb_reg   <= anyb_next;
            end
            act_valid_reg  <= act_valid_next;
            pend_valid_reg <= pend_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // Result group payload.
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        pend_reg <= pend_next;
    end

    // A group in the head slot always holds at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        act_valid_reg |-> (act_reg.nbytes != 2'd0 || act_reg.has_done))
        else $error("empty result group in head slot");

    // The waiting slot is only used behind an occupied head slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> act_valid_reg)
        else $error("waiting group without head group");

    // A done result is the last result of its group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.done_res) |-> out_last)
        else $error("done result is not last in its group");

    // The decoder state is back at reset after an end transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.kind == KIND_END) |=>
            (pos_reg == 2'd0 && !err_reg && !anyb_reg && !pqs_reg))
        else $error("state not cleared after end of string");

endmodule
